// ===== design/vn_pkg.sv =====
// Shared types and constants for the vector normalizer.
package vn_pkg;

  localparam int LANES = 4;
  localparam int ROOT_STEPS = 32;
  localparam int QUOT_BITS = 31;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic signed [31:0] comp_0;
    logic signed [31:0] comp_1;
    logic signed [31:0] comp_2;
    logic signed [31:0] comp_3;
    logic [2:0]         length;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] unit_0;
    logic signed [31:0] unit_1;
    logic signed [31:0] unit_2;
    logic signed [31:0] unit_3;
    logic [31:0]        magnitude;
    logic               degenerate;
  } out_word_t;

  // per-lane data that rides along the pipeline
  typedef struct packed {
    logic [LANES-1:0][31:0] absval;
    logic [LANES-1:0]       neg;
    logic [LANES-1:0]       used;
  } side_t;

endpackage

// ===== design/vn_sumsq.sv =====
// Front end: magnitudes of the components and the sum of their squares.
module vn_sumsq #(
  parameter int MAX_DIM = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  vn_pkg::in_word_t vec,
  output logic             out_valid,
  output logic [63:0]      sum,
  output logic             sat,
  output vn_pkg::side_t    side
);

  localparam int LIM = (MAX_DIM < vn_pkg::LANES) ? MAX_DIM : vn_pkg::LANES;

  logic [vn_pkg::LANES-1:0][31:0] comp;
  logic [2:0]                     n;
  vn_pkg::side_t                  side_in;

  logic          valid_a, valid_b, valid_c, valid_d;
  vn_pkg::side_t side_a, side_b, side_c, side_d;
  logic [63:0]   sq_b [0:vn_pkg::LANES-1];
  logic [64:0]   pair_c [0:1];
  logic [65:0]   sum_d;

  assign comp[0] = vec.comp_0;
  assign comp[1] = vec.comp_1;
  assign comp[2] = vec.comp_2;
  assign comp[3] = vec.comp_3;

  always_comb begin
    if (vec.length == 3'd0) begin
      n = 3'd1;
    end else if (int'(vec.length) > LIM) begin
      n = 3'(LIM);
    end else begin
      n = vec.length;
    end
    for (int i = 0; i < vn_pkg::LANES; i++) begin
      side_in.neg[i]    = comp[i][31];
      side_in.absval[i] = comp[i][31] ? (~comp[i] + 32'd1) : comp[i];
      side_in.used[i]   = (3'(i) < n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      valid_d <= 1'b0;
    end else if (en) begin
      valid_a <= in_valid;
      valid_b <= valid_a;
      valid_c <= valid_b;
      valid_d <= valid_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a <= side_in;
      side_b <= side_a;
      side_c <= side_b;
      side_d <= side_c;
      for (int i = 0; i < vn_pkg::LANES; i++) begin
        sq_b[i] <= side_a.used[i] ?
                   64'(side_a.absval[i]) * 64'(side_a.absval[i]) : 64'd0;
      end
      pair_c[0] <= 65'(sq_b[0]) + 65'(sq_b[1]);
      pair_c[1] <= 65'(sq_b[2]) + 65'(sq_b[3]);
      sum_d     <= 66'(pair_c[0]) + 66'(pair_c[1]);
    end
  end

  assign out_valid = valid_d;
  assign sum       = sum_d[63:0];
  assign sat       = |sum_d[65:64];
  assign side      = side_d;

endmodule

// ===== design/vn_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module vn_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   sum,
  input  logic          sat_in,
  input  vn_pkg::side_t side_in,
  output logic          out_valid,
  output logic [31:0]   mag,
  output vn_pkg::side_t side_out
);

  localparam int N = vn_pkg::ROOT_STEPS;

  logic [32:0]   rem   [0:N];
  logic [31:0]   root  [0:N];
  logic [63:0]   xs    [0:N];
  logic          sat   [0:N];
  vn_pkg::side_t side  [0:N];
  logic          valid [0:N];

  assign rem[0]   = '0;
  assign root[0]  = '0;
  assign xs[0]    = sum;
  assign sat[0]   = sat_in;
  assign side[0]  = side_in;
  assign valid[0] = in_valid;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [34:0] r2;
    logic [34:0] trial;
    logic [32:0] rem_next;
    logic [31:0] root_next;

    always_comb begin
      r2    = {rem[k][32:0], xs[k][63:62]};
      trial = {1'b0, root[k], 2'b01};
      if (r2 >= trial) begin
        rem_next  = 33'(r2 - trial);
        root_next = {root[k][30:0], 1'b1};
      end else begin
        rem_next  = r2[32:0];
        root_next = {root[k][30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= rem_next;
        root[k+1] <= root_next;
        xs[k+1]   <= {xs[k][61:0], 2'b00};
        sat[k+1]  <= sat[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = valid[N];
  assign mag       = sat[N] ? 32'hFFFF_FFFF : root[N];
  assign side_out  = side[N];

endmodule

// ===== design/vn_div.sv =====
// Pipelined restoring divider, four lanes, one quotient bit per stage.
module vn_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [31:0]   mag_in,
  input  logic          degen_in,
  input  vn_pkg::side_t side_in,
  output logic          out_valid,
  output logic [vn_pkg::LANES-1:0][30:0] quot_out,
  output logic [31:0]   mag_out,
  output logic          degen_out,
  output vn_pkg::side_t side_out
);

  localparam int N = vn_pkg::QUOT_BITS;
  localparam int L = vn_pkg::LANES;

  logic [31:0]   rem   [0:L-1][0:N];
  logic [30:0]   quot  [0:L-1][0:N];
  logic [31:0]   mag   [0:N];
  logic          degen [0:N];
  vn_pkg::side_t side  [0:N];
  logic          valid [0:N];

  assign mag[0]   = mag_in;
  assign degen[0] = degen_in;
  assign side[0]  = side_in;
  assign valid[0] = in_valid;

  for (genvar j = 0; j < N; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j+1] <= 1'b0;
      end else if (en) begin
        valid[j+1] <= valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mag[j+1]   <= mag[j];
        degen[j+1] <= degen[j];
        side[j+1]  <= side[j];
      end
    end
  end

  for (genvar l = 0; l < L; l++) begin : g_lane
    // dividend is absval << 30; its top bits seed the remainder
    assign rem[l][0]  = {1'b0, side_in.absval[l][31:1]};
    assign quot[l][0] = '0;

    for (genvar j = 0; j < N; j++) begin : g_step
      logic        dbit;
      logic [32:0] t;
      logic [31:0] rem_next;
      logic        qbit;

      always_comb begin
        dbit = (j == 0) ? side_in.absval[l][0] : 1'b0;
        t    = {rem[l][j], dbit};
        if (t >= {1'b0, mag[j]}) begin
          rem_next = 32'(t - {1'b0, mag[j]});
          qbit     = 1'b1;
        end else begin
          rem_next = t[31:0];
          qbit     = 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[l][j+1]  <= rem_next;
          quot[l][j+1] <= {quot[l][j][29:0], qbit};
        end
      end
    end

    assign quot_out[l] = quot[l][N];
  end

  assign out_valid = valid[N];
  assign mag_out   = mag[N];
  assign degen_out = degen[N];
  assign side_out  = side[N];

endmodule

// ===== design/vn_skid.sv =====
// Two-word output buffer between the pipeline and the result channel.
module vn_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vn_pkg::out_word_t push_word,
  output logic              has_room,
  output logic              res_valid,
  input  logic              res_ready,
  output vn_pkg::out_word_t res
);

  vn_pkg::out_word_t buf_q [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       pop;

  assign pop       = res_valid && res_ready;
  assign res_valid = (cnt != 2'd0);
  assign res       = buf_q[rd_ptr];
  assign has_room  = (cnt != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= push_word;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("skid count overflow");
  assert property (@(posedge clk) disable iff (rst) (cnt == 2'd2) |-> !push)
    else $error("push into full skid buffer");

endmodule

// ===== design/vector_normalize.sv =====
// Top level of the four-lane Euclidean vector normalizer.
//
//  channel     dir  handshake                  word
//  vec         in   vec_valid / vec_ready      vn_pkg::in_word_t
//  res         out  res_valid / res_ready      vn_pkg::out_word_t
//  min_norm    in   min_norm_we                min_norm_wdata (32 b)
//
// One word enters per cycle while the pipeline is not stalled; it passes
// through 69 register stages (the first loads at the accepting edge):
// 4 stages of abs/square/add, 32 square-root stages (one root bit each),
// 1 threshold stage, 31 divider stages (one quotient bit each), 1 buffer.
// The whole pipeline advances together; it holds only while its last
// stage carries a word and the two-word output buffer is full.
// rst is synchronous and clears the valid bits and min_norm (to 1).
module vector_normalize #(
  parameter int MAX_DIM = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              vec_valid,
  output logic              vec_ready,
  input  vn_pkg::in_word_t  vec,
  output logic              res_valid,
  input  logic              res_ready,
  output vn_pkg::out_word_t res,
  input  logic              min_norm_we,
  input  logic [31:0]       min_norm_wdata
);

  logic          en;
  logic [31:0]   min_norm;

  // sum of squares
  logic          sq_valid;
  logic [63:0]   sq_sum;
  logic          sq_sat;
  vn_pkg::side_t sq_side;

  // square root
  logic          rt_valid;
  logic [31:0]   rt_mag;
  vn_pkg::side_t rt_side;

  // threshold stage
  logic          th_valid;
  logic [31:0]   th_mag;
  logic          th_degen;
  vn_pkg::side_t th_side;

  // divider
  logic                              dv_valid;
  logic [vn_pkg::LANES-1:0][30:0]    dv_quot;
  logic [31:0]                       dv_mag;
  logic                              dv_degen;
  vn_pkg::side_t                     dv_side;

  logic                              has_room;
  logic [vn_pkg::LANES-1:0][31:0]    unit;
  vn_pkg::out_word_t                 word_out;

  // stall only when the last stage holds a word with nowhere to go
  assign en        = !dv_valid || has_room;
  assign vec_ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_norm <= 32'd1;
    end else if (min_norm_we) begin
      min_norm <= min_norm_wdata;
    end
  end

  vn_sumsq #(.MAX_DIM(MAX_DIM)) u_sumsq (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vec_valid),
    .vec      (vec),
    .out_valid(sq_valid),
    .sum      (sq_sum),
    .sat      (sq_sat),
    .side     (sq_side)
  );

  vn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sq_valid),
    .sum      (sq_sum),
    .sat_in   (sq_sat),
    .side_in  (sq_side),
    .out_valid(rt_valid),
    .mag      (rt_mag),
    .side_out (rt_side)
  );

  // zero magnitude is degenerate even with a zero threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      th_valid <= 1'b0;
    end else if (en) begin
      th_valid <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_mag   <= rt_mag;
      th_degen <= (rt_mag == 32'd0) || (rt_mag < min_norm);
      th_side  <= rt_side;
    end
  end

  vn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (th_valid),
    .mag_in   (th_mag),
    .degen_in (th_degen),
    .side_in  (th_side),
    .out_valid(dv_valid),
    .quot_out (dv_quot),
    .mag_out  (dv_mag),
    .degen_out(dv_degen),
    .side_out (dv_side)
  );

  // sign, unused-lane zeroing and the unit-x fallback
  always_comb begin
    for (int i = 0; i < vn_pkg::LANES; i++) begin
      if (!dv_side.used[i]) begin
        unit[i] = 32'd0;
      end else if (dv_side.neg[i]) begin
        unit[i] = 32'd0 - {1'b0, dv_quot[i]};
      end else begin
        unit[i] = {1'b0, dv_quot[i]};
      end
    end
    if (dv_degen) begin
      word_out.unit_0     = vn_pkg::ONE_Q30;
      word_out.unit_1     = 32'd0;
      word_out.unit_2     = 32'd0;
      word_out.unit_3     = 32'd0;
      word_out.magnitude  = vn_pkg::ONE_Q16;
      word_out.degenerate = 1'b1;
    end else begin
      word_out.unit_0     = unit[0];
      word_out.unit_1     = unit[1];
      word_out.unit_2     = unit[2];
      word_out.unit_3     = unit[3];
      word_out.magnitude  = dv_mag;
      word_out.degenerate = 1'b0;
    end
  end

  vn_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (dv_valid && en),
    .push_word(word_out),
    .has_room (has_room),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assert property (@(posedge clk) disable iff (rst)
      (res_valid && res.degenerate) |-> (res.magnitude == vn_pkg::ONE_Q16))
    else $error("degenerate word without unit magnitude");
  assert property (@(posedge clk) disable iff (rst)
      (dv_valid && !en) |=> (dv_valid && $stable(dv_mag)))
    else $error("stalled last stage lost its word");
  assert property (@(posedge clk) disable iff (rst)
      (dv_valid && !dv_degen) |-> (dv_quot[0] <= 31'(vn_pkg::ONE_Q30)))
    else $error("quotient above one");

endmodule
